// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Both sample on clk_i and are
// switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SSD_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ssd_pkg.sv =====
package ssd_pkg;

  // Default coordinate width (signed fixed point).
  localparam int COORD_BITS = 24;

  // Segment parameters are unsigned 0.16 fractions with one extra bit for 1.0.
  localparam int PARAM_BITS = 16;
  localparam logic [PARAM_BITS:0] PARAM_ONE = {1'b1, {PARAM_BITS{1'b0}}};

  // Zero threshold register.
  localparam int          THR_BITS  = 32;
  localparam logic [31:0] THR_RESET = 32'd1;

endpackage

// ===== hw/rtl/ssd_wmul.sv =====
module ssd_wmul #(
  parameter int W = 51
) (
  input  logic                  clk_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  output logic signed [2*W-1:0] p_o
);

  // Signed product split into four partial products, which are registered and summed in the next cycle.
  localparam int L = W / 2;
  localparam int H = W - L;

  logic signed [H-1:0]   ah, bh;
  logic        [L-1:0]   al, bl;
  logic signed [2*H-1:0] hh_d, hh_q;
  logic signed [H+L:0]   hl_d, hl_q, lh_d, lh_q;
  logic        [2*L-1:0] ll_d, ll_q;
  logic signed [2*W-1:0] p_d, p_q;

  assign ah = a_i[W-1:L];
  assign bh = b_i[W-1:L];
  assign al = a_i[L-1:0];
  assign bl = b_i[L-1:0];

  assign hh_d = ah * bh;
  assign hl_d = ah * $signed({1'b0, bl});
  assign lh_d = $signed({1'b0, al}) * bh;
  assign ll_d = al * bl;

  assign p_d = ((2*W)'(hh_q) <<< (2*L))
             + (((2*W)'(hl_q) + (2*W)'(lh_q)) <<< L)
             + $signed({{(2*W-2*L){1'b0}}, ll_q});

  always_ff @(posedge clk_i) begin
    hh_q <= hh_d;
    hl_q <= hl_d;
    lh_q <= lh_d;
    ll_q <= ll_d;
    p_q  <= p_d;
  end

  assign p_o = p_q;

endmodule

// ===== hw/rtl/segment_segment_distance.sv =====
// Pipeline: done_o marks a request leaving the last stage, ST_OUT; the 17-step restoring
//   divider pipeline is the longest part of it.
// Throughput: one request per clock cycle; busy is never asserted.
// Reset: rst_ni clears every valid bit and sets zero_threshold to 1.
// The receiver cannot stall; each result is shown for exactly one cycle.
`include "assert_macros.svh"

module segment_segment_distance #(
  parameter int COORD_BITS = ssd_pkg::COORD_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we_i,
  input  logic [ssd_pkg::THR_BITS-1:0]  cfg_wdata_i,
  input  logic signed [COORD_BITS-1:0]  a_start_x_i,
  input  logic signed [COORD_BITS-1:0]  a_start_y_i,
  input  logic signed [COORD_BITS-1:0]  a_end_x_i,
  input  logic signed [COORD_BITS-1:0]  a_end_y_i,
  input  logic signed [COORD_BITS-1:0]  b_start_x_i,
  input  logic signed [COORD_BITS-1:0]  b_start_y_i,
  input  logic signed [COORD_BITS-1:0]  b_end_x_i,
  input  logic signed [COORD_BITS-1:0]  b_end_y_i,
  output logic                          done_o,
  output logic signed [COORD_BITS-1:0]  near_a_x_o,
  output logic signed [COORD_BITS-1:0]  near_a_y_o,
  output logic signed [COORD_BITS-1:0]  near_b_x_o,
  output logic signed [COORD_BITS-1:0]  near_b_y_o,
  output logic [2*COORD_BITS:0]         dist_squared_o
);
  import ssd_pkg::*;

  // Widths. VW holds an edge vector, DW a dot product, NW the determinant
  // and the parameter numerators, UW their positive magnitude.
  localparam int VW  = COORD_BITS + 1;
  localparam int DW  = 2 * VW + 1;
  localparam int NW  = 2 * DW + 1;
  localparam int UW  = NW - 1;
  localparam int QW  = PARAM_BITS + 1;
  localparam int RW  = UW + PARAM_BITS;
  localparam int PW  = QW + 1 + VW;
  localparam int DSW = 2 * COORD_BITS + 1;
  localparam int SW  = 2 * VW + 1;

  // Pipeline stage numbers. A stage's registers are written at the edge that
  // moves an item into that stage.
  localparam int ST_DOT  = 2;                // dot products a..e
  localparam int ST_MUL  = 4;                // wide products (partial products, then sum)
  localparam int ST_DET  = 5;                // D and the raw numerators
  localparam int ST_S1   = 6;                // parallel test and first clamp
  localparam int ST_S2   = 7;                // clamp of t and re-projection of s
  localparam int ST_DP   = 8;                // threshold test and divider setup
  localparam int ST_DVL  = ST_DP + QW;       // last divider step
  localparam int ST_PRD  = ST_DVL + 1;       // parameter times edge
  localparam int ST_NEAR = ST_PRD + 1;       // closest points
  localparam int ST_DIF  = ST_NEAR + 1;      // point differences
  localparam int ST_OUT  = ST_DIF + 1;       // squared distance, result strobe

  localparam logic signed [PW:0] HALF = (PW+1)'(1) <<< (PARAM_BITS - 1);
  localparam logic [DSW-1:0]     DMAX = {DSW{1'b1}};

  // The whole datapath advances every cycle, so a request is taken whenever
  // start is high.
  assign busy = 1'b0;

  logic [ST_OUT:1] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[ST_OUT-1:1], start & ~busy};
    end
  end

  assign done_o = v_q[ST_OUT];

  // Zero threshold. The user must write it only while no request is in flight; the block does not enforce this.
  logic [THR_BITS-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  logic signed [NW-1:0] thr_n;
  assign thr_n = $signed({{(NW-THR_BITS){1'b0}}, thr_q});

  // ---------------------------------------------------------------------
  // Stage 1: edge vectors u = A.end - A.start, v = B.end - B.start and the
  // offset w = A.start - B.start. The start points ride along until the
  // closest points are formed, the edges until they are scaled.
  // ---------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] p1x_q [1:ST_PRD];
  logic signed [COORD_BITS-1:0] p1y_q [1:ST_PRD];
  logic signed [COORD_BITS-1:0] p3x_q [1:ST_PRD];
  logic signed [COORD_BITS-1:0] p3y_q [1:ST_PRD];
  logic signed [VW-1:0]         ux_q  [1:ST_DVL];
  logic signed [VW-1:0]         uy_q  [1:ST_DVL];
  logic signed [VW-1:0]         vx_q  [1:ST_DVL];
  logic signed [VW-1:0]         vy_q  [1:ST_DVL];
  logic signed [VW-1:0]         wx_q, wy_q;

  always_ff @(posedge clk_i) begin
    p1x_q[1] <= a_start_x_i;
    p1y_q[1] <= a_start_y_i;
    p3x_q[1] <= b_start_x_i;
    p3y_q[1] <= b_start_y_i;
    ux_q[1]  <= VW'(a_end_x_i) - VW'(a_start_x_i);
    uy_q[1]  <= VW'(a_end_y_i) - VW'(a_start_y_i);
    vx_q[1]  <= VW'(b_end_x_i) - VW'(b_start_x_i);
    vy_q[1]  <= VW'(b_end_y_i) - VW'(b_start_y_i);
    wx_q     <= VW'(a_start_x_i) - VW'(b_start_x_i);
    wy_q     <= VW'(a_start_y_i) - VW'(b_start_y_i);
    for (int k = 2; k <= ST_PRD; k++) begin
      p1x_q[k] <= p1x_q[k-1];
      p1y_q[k] <= p1y_q[k-1];
      p3x_q[k] <= p3x_q[k-1];
      p3y_q[k] <= p3y_q[k-1];
    end
    for (int k = 2; k <= ST_DVL; k++) begin
      ux_q[k] <= ux_q[k-1];
      uy_q[k] <= uy_q[k-1];
      vx_q[k] <= vx_q[k-1];
      vy_q[k] <= vy_q[k-1];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: dot products a = u.u, b = u.v, c = v.v, d = u.w, e = v.w.
  // ---------------------------------------------------------------------
  logic signed [2*VW-1:0] m_uxux, m_uyuy, m_uxvx, m_uyvy, m_vxvx, m_vyvy;
  logic signed [2*VW-1:0] m_uxwx, m_uywy, m_vxwx, m_vywy;

  assign m_uxux = ux_q[1] * ux_q[1];
  assign m_uyuy = uy_q[1] * uy_q[1];
  assign m_uxvx = ux_q[1] * vx_q[1];
  assign m_uyvy = uy_q[1] * vy_q[1];
  assign m_vxvx = vx_q[1] * vx_q[1];
  assign m_vyvy = vy_q[1] * vy_q[1];
  assign m_uxwx = ux_q[1] * wx_q;
  assign m_uywy = uy_q[1] * wy_q;
  assign m_vxwx = vx_q[1] * wx_q;
  assign m_vywy = vy_q[1] * wy_q;

  logic signed [DW-1:0] da_q [ST_DOT:ST_S1];
  logic signed [DW-1:0] db_q [ST_DOT:ST_S1];
  logic signed [DW-1:0] dd_q [ST_DOT:ST_S1];
  logic signed [DW-1:0] dc_q [ST_DOT:ST_DET];
  logic signed [DW-1:0] de_q [ST_DOT:ST_DET];

  always_ff @(posedge clk_i) begin
    da_q[ST_DOT] <= DW'(m_uxux) + DW'(m_uyuy);
    db_q[ST_DOT] <= DW'(m_uxvx) + DW'(m_uyvy);
    dc_q[ST_DOT] <= DW'(m_vxvx) + DW'(m_vyvy);
    dd_q[ST_DOT] <= DW'(m_uxwx) + DW'(m_uywy);
    de_q[ST_DOT] <= DW'(m_vxwx) + DW'(m_vywy);
    for (int k = ST_DOT + 1; k <= ST_S1; k++) begin
      da_q[k] <= da_q[k-1];
      db_q[k] <= db_q[k-1];
      dd_q[k] <= dd_q[k-1];
    end
    for (int k = ST_DOT + 1; k <= ST_DET; k++) begin
      dc_q[k] <= dc_q[k-1];
      de_q[k] <= de_q[k-1];
    end
  end

  // ---------------------------------------------------------------------
  // Stages 3 and 4: the six wide products, each split into partial products.
  // ---------------------------------------------------------------------
  logic signed [2*DW-1:0] p_ac, p_bb, p_be, p_cd, p_ae, p_bd;

  ssd_wmul #(.W(DW)) u_mul_ac (.clk_i(clk_i), .a_i(da_q[ST_DOT]), .b_i(dc_q[ST_DOT]), .p_o(p_ac));
  ssd_wmul #(.W(DW)) u_mul_bb (.clk_i(clk_i), .a_i(db_q[ST_DOT]), .b_i(db_q[ST_DOT]), .p_o(p_bb));
  ssd_wmul #(.W(DW)) u_mul_be (.clk_i(clk_i), .a_i(db_q[ST_DOT]), .b_i(de_q[ST_DOT]), .p_o(p_be));
  ssd_wmul #(.W(DW)) u_mul_cd (.clk_i(clk_i), .a_i(dc_q[ST_DOT]), .b_i(dd_q[ST_DOT]), .p_o(p_cd));
  ssd_wmul #(.W(DW)) u_mul_ae (.clk_i(clk_i), .a_i(da_q[ST_DOT]), .b_i(de_q[ST_DOT]), .p_o(p_ae));
  ssd_wmul #(.W(DW)) u_mul_bd (.clk_i(clk_i), .a_i(db_q[ST_DOT]), .b_i(dd_q[ST_DOT]), .p_o(p_bd));

  // ---------------------------------------------------------------------
  // Stage 5: determinant D = a*c - b*b and the unclamped numerators.
  // ---------------------------------------------------------------------
  logic signed [NW-1:0] det_q, sn5_q, tn5_q;

  always_ff @(posedge clk_i) begin
    det_q <= NW'(p_ac) - NW'(p_bb);
    sn5_q <= NW'(p_be) - NW'(p_cd);
    tn5_q <= NW'(p_ae) - NW'(p_bd);
  end

  // ---------------------------------------------------------------------
  // Stage 6: a determinant below the threshold means parallel segments, and
  // s is pinned to the start of A. Otherwise s is clamped to [0, D], and
  // when it is clamped t is recomputed against the chosen end of A.
  // ---------------------------------------------------------------------
  logic signed [NW-1:0] e5_n, c5_n, b5_n;
  logic signed [NW-1:0] sn6_d, sd6_d, tn6_d, td6_d;
  logic signed [NW-1:0] sn6_q, sd6_q, tn6_q, td6_q;
  logic                 par6, sneg6, sgt6;

  assign e5_n  = NW'(de_q[ST_DET]);
  assign c5_n  = NW'(dc_q[ST_DET]);
  assign b5_n  = NW'(db_q[ST_DET]);
  assign par6  = det_q < thr_n;
  assign sneg6 = sn5_q < 0;
  assign sgt6  = sn5_q > det_q;

  always_comb begin
    sn6_d = sn5_q;
    sd6_d = det_q;
    tn6_d = tn5_q;
    td6_d = det_q;
    if (par6) begin
      sn6_d = '0;
      sd6_d = NW'(1);
      tn6_d = e5_n;
      td6_d = c5_n;
    end else if (sneg6) begin
      sn6_d = '0;
      tn6_d = e5_n;
      td6_d = c5_n;
    end else if (sgt6) begin
      sn6_d = det_q;
      tn6_d = e5_n + b5_n;
      td6_d = c5_n;
    end
  end

  always_ff @(posedge clk_i) begin
    sn6_q <= sn6_d;
    sd6_q <= sd6_d;
    tn6_q <= tn6_d;
    td6_q <= td6_d;
  end

  // ---------------------------------------------------------------------
  // Stage 7: clamp t to [0, tD]. When it is clamped, s is projected again
  // onto A from the chosen end of B (numerator -d or b - d over a) and
  // clamped to A's ends.
  // ---------------------------------------------------------------------
  logic signed [NW-1:0] a6_n, b6_n, d6_n, proj7;
  logic signed [NW-1:0] sn7_d, sd7_d, tn7_d;
  logic signed [NW-1:0] sn7_q, sd7_q, tn7_q, td7_q;
  logic                 tneg7, tgt7;

  assign a6_n  = NW'(da_q[ST_S1]);
  assign b6_n  = NW'(db_q[ST_S1]);
  assign d6_n  = NW'(dd_q[ST_S1]);
  assign tneg7 = tn6_q < 0;
  assign tgt7  = tn6_q > td6_q;
  assign proj7 = tneg7 ? -d6_n : (b6_n - d6_n);

  always_comb begin
    sn7_d = sn6_q;
    sd7_d = sd6_q;
    tn7_d = tn6_q;
    if (tneg7 || tgt7) begin
      tn7_d = tneg7 ? '0 : td6_q;
      if (proj7 < 0) begin
        sn7_d = '0;
      end else if (proj7 > a6_n) begin
        sn7_d = sd6_q;
      end else begin
        sn7_d = proj7;
        sd7_d = a6_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sn7_q <= sn7_d;
    sd7_q <= sd7_d;
    tn7_q <= tn7_d;
    td7_q <= td6_q;
  end

  // ---------------------------------------------------------------------
  // Stage 8: a numerator whose magnitude is below the threshold, or any
  // non-positive numerator or divisor, yields a zero parameter. Such items
  // enter the divider as 0 / 1.
  // ---------------------------------------------------------------------
  logic signed [NW-1:0] smag8, tmag8;
  logic                 szero8, tzero8;

  assign smag8  = sn7_q[NW-1] ? -sn7_q : sn7_q;
  assign tmag8  = tn7_q[NW-1] ? -tn7_q : tn7_q;
  assign szero8 = ($unsigned(smag8) < $unsigned(thr_n)) || (sn7_q <= 0) || (sd7_q <= 0);
  assign tzero8 = ($unsigned(tmag8) < $unsigned(thr_n)) || (tn7_q <= 0) || (td7_q <= 0);

  // Divider state, index 0 for s and 1 for t. Step j resolves quotient bit
  // QW-j by one compare and subtract of the shifted divisor.
  logic [UW-1:0] rem_q [2][0:QW-1];
  logic [UW-1:0] den_q [2][0:QW-1];
  logic [QW-1:0] quo_q [2][1:QW];

  always_ff @(posedge clk_i) begin
    rem_q[0][0] <= szero8 ? '0 : sn7_q[UW-1:0];
    den_q[0][0] <= szero8 ? UW'(1) : sd7_q[UW-1:0];
    rem_q[1][0] <= tzero8 ? '0 : tn7_q[UW-1:0];
    den_q[1][0] <= tzero8 ? UW'(1) : td7_q[UW-1:0];
  end

  for (genvar j = 1; j <= QW; j++) begin : g_div
    localparam int BIT = QW - j;
    logic [RW-1:0] sub  [2];
    logic          ge   [2];
    logic [QW-1:0] qin  [2];

    for (genvar x = 0; x < 2; x++) begin : g_side
      assign sub[x] = RW'(den_q[x][j-1]) << BIT;
      assign ge[x]  = RW'(rem_q[x][j-1]) >= sub[x];
      if (j == 1) begin : g_first
        assign qin[x] = '0;
      end else begin : g_rest
        assign qin[x] = quo_q[x][j-1];
      end

      always_ff @(posedge clk_i) begin
        quo_q[x][j] <= {qin[x][QW-2:0], ge[x]};
      end

      if (j < QW) begin : g_carry
        always_ff @(posedge clk_i) begin
          rem_q[x][j] <= ge[x] ? (rem_q[x][j-1] - sub[x][UW-1:0]) : rem_q[x][j-1];
          den_q[x][j] <= den_q[x][j-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 26: saturate the parameters at 1.0 and scale the edges.
  // ---------------------------------------------------------------------
  logic [QW-1:0]        sc_n, tc_n;
  logic signed [PW-1:0] pax_q, pay_q, pbx_q, pby_q;

  assign sc_n = (quo_q[0][QW] > PARAM_ONE) ? PARAM_ONE : quo_q[0][QW];
  assign tc_n = (quo_q[1][QW] > PARAM_ONE) ? PARAM_ONE : quo_q[1][QW];

  always_ff @(posedge clk_i) begin
    pax_q <= $signed({1'b0, sc_n}) * ux_q[ST_DVL];
    pay_q <= $signed({1'b0, sc_n}) * uy_q[ST_DVL];
    pbx_q <= $signed({1'b0, tc_n}) * vx_q[ST_DVL];
    pby_q <= $signed({1'b0, tc_n}) * vy_q[ST_DVL];
  end

  // ---------------------------------------------------------------------
  // Stage 27: closest points. The scaled edge is rounded half up, which is
  // an add of one half and an arithmetic shift, and added to the start.
  // ---------------------------------------------------------------------
  logic signed [PW:0]           rax, ray, rbx, rby;
  logic signed [VW-1:0]         nax_w, nay_w, nbx_w, nby_w;
  logic signed [COORD_BITS-1:0] nax_q [ST_NEAR:ST_DIF];
  logic signed [COORD_BITS-1:0] nay_q [ST_NEAR:ST_DIF];
  logic signed [COORD_BITS-1:0] nbx_q [ST_NEAR:ST_DIF];
  logic signed [COORD_BITS-1:0] nby_q [ST_NEAR:ST_DIF];

  assign rax = ((PW+1)'(pax_q) + HALF) >>> PARAM_BITS;
  assign ray = ((PW+1)'(pay_q) + HALF) >>> PARAM_BITS;
  assign rbx = ((PW+1)'(pbx_q) + HALF) >>> PARAM_BITS;
  assign rby = ((PW+1)'(pby_q) + HALF) >>> PARAM_BITS;

  assign nax_w = VW'(p1x_q[ST_PRD]) + rax[VW-1:0];
  assign nay_w = VW'(p1y_q[ST_PRD]) + ray[VW-1:0];
  assign nbx_w = VW'(p3x_q[ST_PRD]) + rbx[VW-1:0];
  assign nby_w = VW'(p3y_q[ST_PRD]) + rby[VW-1:0];

  always_ff @(posedge clk_i) begin
    nax_q[ST_NEAR] <= nax_w[COORD_BITS-1:0];
    nay_q[ST_NEAR] <= nay_w[COORD_BITS-1:0];
    nbx_q[ST_NEAR] <= nbx_w[COORD_BITS-1:0];
    nby_q[ST_NEAR] <= nby_w[COORD_BITS-1:0];
    nax_q[ST_DIF]  <= nax_q[ST_NEAR];
    nay_q[ST_DIF]  <= nay_q[ST_NEAR];
    nbx_q[ST_DIF]  <= nbx_q[ST_NEAR];
    nby_q[ST_DIF]  <= nby_q[ST_NEAR];
  end

  // ---------------------------------------------------------------------
  // Stages 28 and 29: point differences, then the squared distance, which
  // saturates at the top of its range.
  // ---------------------------------------------------------------------
  logic signed [VW-1:0]   dx_q, dy_q;
  logic signed [2*VW-1:0] sqx, sqy;
  logic        [SW-1:0]   dsum;

  always_ff @(posedge clk_i) begin
    dx_q <= VW'(nbx_q[ST_NEAR]) - VW'(nax_q[ST_NEAR]);
    dy_q <= VW'(nby_q[ST_NEAR]) - VW'(nay_q[ST_NEAR]);
  end

  assign sqx  = dx_q * dx_q;
  assign sqy  = dy_q * dy_q;
  assign dsum = $unsigned(SW'(sqx)) + $unsigned(SW'(sqy));

  always_ff @(posedge clk_i) begin
    near_a_x_o     <= nax_q[ST_DIF];
    near_a_y_o     <= nay_q[ST_DIF];
    near_b_x_o     <= nbx_q[ST_DIF];
    near_b_y_o     <= nby_q[ST_DIF];
    dist_squared_o <= (dsum > SW'(DMAX)) ? DMAX : dsum[DSW-1:0];
  end

  // ---------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------
  `SSD_ASSERT_NEXT(a_det_nonneg, v_q[ST_MUL], !det_q[NW-1], "determinant came out negative")
  `SSD_ASSERT(a_s_in_range, v_q[ST_S2], !sn7_q[NW-1] && (sn7_q <= sd7_q), "s numerator out of range")
  `SSD_ASSERT(a_t_in_range, v_q[ST_S2], !tn7_q[NW-1] && (tn7_q <= td7_q), "t numerator out of range")
  `SSD_ASSERT(a_same_point, done_o && (near_a_x_o == near_b_x_o) && (near_a_y_o == near_b_y_o), dist_squared_o == '0, "coincident points with nonzero distance")

endmodule

// ===== tb/sv/segment_segment_distance_test.sv =====
`default_nettype none

module segment_segment_distance_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ssd_pkg::*;

  localparam int CB = ssd_pkg::COORD_BITS;
  // Covers the pipeline depth of the top level, plus margin.
  localparam int SETTLE_CYCLES = 40;

  typedef logic signed [CB-1:0] coord_t;
  // Wide enough for products of dot products with plenty of headroom.
  typedef logic signed [159:0] big_t;

  typedef struct packed {
    coord_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  } seg_pair_t;

  typedef struct packed {
    coord_t nax, nay, nbx, nby;
    logic [2*CB:0] dist_sq;
  } closest_t;

  typedef enum logic [1:0] {REQ_ITEM, REQ_CONFIG, REQ_DRAIN} req_kind_e;

  typedef struct {
    req_kind_e kind;
    seg_pair_t pair;
    logic [THR_BITS-1:0] thr;
    int unsigned gap;
  } request_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cfg_we_i = 1'b0;
  logic [THR_BITS-1:0] cfg_wdata_i = '0;
  seg_pair_t drive_pair = '0;
  logic done_o;
  coord_t near_a_x_o, near_a_y_o, near_b_x_o, near_b_y_o;
  logic [2*CB:0] dist_squared_o;

  request_t pending_requests[$];
  closest_t expected_points[$];
  logic [THR_BITS-1:0] thr_shadow = THR_RESET;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned gap_left = 0;

  segment_segment_distance dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .a_start_x_i   (drive_pair.ax0),
    .a_start_y_i   (drive_pair.ay0),
    .a_end_x_i     (drive_pair.ax1),
    .a_end_y_i     (drive_pair.ay1),
    .b_start_x_i   (drive_pair.bx0),
    .b_start_y_i   (drive_pair.by0),
    .b_end_x_i     (drive_pair.bx1),
    .b_end_y_i     (drive_pair.by1),
    .done_o        (done_o),
    .near_a_x_o    (near_a_x_o),
    .near_a_y_o    (near_a_y_o),
    .near_b_x_o    (near_b_x_o),
    .near_b_y_o    (near_b_y_o),
    .dist_squared_o(dist_squared_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // A segment parameter as a 0.16 fraction. Small numerators count as zero,
  // a non-positive numerator or divisor gives zero, and the quotient
  // saturates at 1.0.
  function automatic longint seg_fraction(big_t num, big_t den, big_t thr);
    big_t mag;
    big_t rem;
    big_t trial;
    longint q;
    mag = (num < 0) ? -num : num;
    q = 0;
    if (mag < thr || num <= 0 || den <= 0) return 0;
    rem = num;
    for (int bit_pos = PARAM_BITS; bit_pos >= 0; bit_pos--) begin
      trial = den <<< bit_pos;
      if (rem >= trial) begin
        rem = rem - trial;
        q = q | (longint'(1) << bit_pos);
      end
    end
    if (q > (longint'(1) << PARAM_BITS)) q = longint'(1) << PARAM_BITS;
    return q;
  endfunction

  // Rounds param * edge / 2^16 half toward plus infinity and adds the start.
  function automatic longint point_on(longint origin, longint frac, longint edge_len);
    return origin + ((frac * edge_len + (longint'(1) << (PARAM_BITS - 1))) >>> PARAM_BITS);
  endfunction

  // Closest points between the two segments, by solving for the parameters s and
  // t and clamping each to its segment, with exact integer dot products.
  function automatic closest_t closest_points(seg_pair_t p, logic [THR_BITS-1:0] thr_reg);
    longint p1x, p1y, p3x, p3y, ux, uy, vx, vy, wx, wy;
    longint sc, tc, nax, nay, nbx, nby, dx, dy, sq_dist, dmax;
    big_t a, b, c, d, e, det, thr, s_num, s_den, t_num, t_den, m;
    bit clamp_t;
    closest_t r;
    p1x = longint'(p.ax0); p1y = longint'(p.ay0);
    p3x = longint'(p.bx0); p3y = longint'(p.by0);
    ux = longint'(p.ax1) - p1x; uy = longint'(p.ay1) - p1y;
    vx = longint'(p.bx1) - p3x; vy = longint'(p.by1) - p3y;
    wx = p1x - p3x; wy = p1y - p3y;
    a = big_t'(ux * ux) + big_t'(uy * uy);
    b = big_t'(ux * vx) + big_t'(uy * vy);
    c = big_t'(vx * vx) + big_t'(vy * vy);
    d = big_t'(ux * wx) + big_t'(uy * wy);
    e = big_t'(vx * wx) + big_t'(vy * wy);
    det = a * c - b * b;
    thr = '0;
    thr[THR_BITS-1:0] = thr_reg;
    s_den = det;
    t_den = det;
    if (det < thr) begin
      // Parallel or nearly so: pin s to the start of A.
      s_num = 0; s_den = 1; t_num = e; t_den = c;
    end else begin
      s_num = b * e - c * d;
      t_num = a * e - b * d;
      if (s_num < 0) begin
        s_num = 0; t_num = e; t_den = c;
      end else if (s_num > s_den) begin
        s_num = s_den; t_num = e + b; t_den = c;
      end
    end
    // When t leaves its range, clamp it and recompute s against that end of B.
    clamp_t = 1'b1;
    m = 0;
    if (t_num < 0) begin
      t_num = 0;
      m = -d;
    end else if (t_num > t_den) begin
      t_num = t_den;
      m = b - d;
    end else begin
      clamp_t = 1'b0;
    end
    if (clamp_t) begin
      if (m < 0) s_num = 0;
      else if (m > a) s_num = s_den;
      else begin
        s_num = m; s_den = a;
      end
    end
    sc = seg_fraction(s_num, s_den, thr);
    tc = seg_fraction(t_num, t_den, thr);
    nax = point_on(p1x, sc, ux);
    nay = point_on(p1y, sc, uy);
    nbx = point_on(p3x, tc, vx);
    nby = point_on(p3y, tc, vy);
    dx = nbx - nax;
    dy = nby - nay;
    sq_dist = dx * dx + dy * dy;
    dmax = (longint'(1) << (2 * CB + 1)) - 1;
    if (sq_dist > dmax) sq_dist = dmax;
    r.nax = coord_t'(nax);
    r.nay = coord_t'(nay);
    r.nbx = coord_t'(nbx);
    r.nby = coord_t'(nby);
    r.dist_sq = sq_dist[2*CB:0];
    return r;
  endfunction

  // Driver: presents requests from the queue, holds config writes until the
  // pipeline has drained, and inserts the gap stored with each request.
  always @(posedge clk_i or negedge rst_ni) begin
    request_t head;
    logic next_start;
    logic next_we;
    if (!rst_ni) begin
      start <= 1'b0;
      cfg_we_i <= 1'b0;
      quiet_cycles <= 0;
      gap_left <= 0;
    end else begin
      next_start = 1'b0;
      next_we = 1'b0;
      if (start && !busy) begin
        expected_points = {expected_points, closest_points(drive_pair, thr_shadow)};
        quiet_cycles <= 0;
      end else if (quiet_cycles < 1000) begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (start && busy) begin
        // Not accepted yet: keep presenting the same request.
        next_start = 1'b1;
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_requests.size() != 0) begin
        head = pending_requests[0];
        case (head.kind)
          REQ_ITEM: begin
            drive_pair <= head.pair;
            next_start = 1'b1;
            gap_left <= head.gap;
            void'(pending_requests.pop_front());
          end
          REQ_CONFIG: begin
            // Only write once nothing is in flight inside the block.
            if (!start && expected_points.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
              next_we = 1'b1;
              cfg_wdata_i <= head.thr;
              thr_shadow <= head.thr;
              void'(pending_requests.pop_front());
            end
          end
          default: begin
            if (expected_points.size() == 0) void'(pending_requests.pop_front());
          end
        endcase
      end
      start <= next_start;
      cfg_we_i <= next_we;
    end
  end

  // Monitor: every done strobe must match the oldest expectation.
  always @(posedge clk_i) begin
    closest_t want;
    closest_t got;
    if (rst_ni && done_o) begin
      got = '{near_a_x_o, near_a_y_o, near_b_x_o, near_b_y_o, dist_squared_o};
      if (expected_points.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_points.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  function automatic coord_t rand_coord(int unsigned span_bits);
    logic [31:0] raw;
    raw = $urandom;
    if (span_bits >= CB) return coord_t'(raw);
    return coord_t'($signed(raw[CB-1:0]) >>> (CB - span_bits));
  endfunction

  function automatic int unsigned rand_gap(bit steady);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Random segment pairs: mostly small boxes so the geometry branches all
  // trigger, with full-range, parallel, point-like and touching pairs mixed in.
  function automatic seg_pair_t rand_pair();
    seg_pair_t p;
    int unsigned shape;
    int unsigned span;
    coord_t dx, dy;
    int k;
    shape = $urandom_range(0, 9);
    span = (shape < 4) ? $urandom_range(4, 16) : (shape < 6 ? CB : $urandom_range(8, 21));
    p = '{rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span),
          rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span)};
    case (shape)
      6: begin
        // B is a scaled copy of A's direction, often overlapping it.
        dx = p.ax1 - p.ax0;
        dy = p.ay1 - p.ay0;
        k = $urandom_range(0, 4) - 2;
        p.bx1 = p.bx0 + coord_t'(k * dx);
        p.by1 = p.by0 + coord_t'(k * dy);
        if ($urandom_range(0, 1)) begin
          p.bx0 = p.ax0 + coord_t'($urandom_range(0, 1) * dx);
          p.by0 = p.ay0 + coord_t'($urandom_range(0, 1) * dy);
        end
      end
      7: begin
        if ($urandom_range(0, 1)) begin
          p.ax1 = p.ax0; p.ay1 = p.ay0;
        end
        if ($urandom_range(0, 1)) begin
          p.bx1 = p.bx0; p.by1 = p.by0;
        end
      end
      9: begin
        p.bx0 = p.ax1; p.by0 = p.ay1;
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic add_pair(input seg_pair_t p, input int unsigned gap);
    request_t r;
    r.kind = REQ_ITEM;
    r.pair = p;
    r.thr = '0;
    r.gap = gap;
    pending_requests = {pending_requests, r};
  endtask

  task automatic add_marker(input req_kind_e kind, input logic [THR_BITS-1:0] thr);
    request_t r;
    r.kind = kind;
    r.pair = '0;
    r.thr = thr;
    r.gap = 0;
    pending_requests = {pending_requests, r};
  endtask

  task automatic add_random_phase(input int unsigned count);
    bit steady;
    steady = 1'b0;
    for (int i = 0; i < count; i++) begin
      // Switch now and then between gapped traffic and back-to-back bursts.
      if ($urandom_range(0, 49) == 0) steady = !steady;
      add_pair(rand_pair(), rand_gap(steady));
    end
  endtask

  initial begin
    coord_t hi, lo;
    logic [THR_BITS-1:0] thr_plan[6];
    hi = {1'b0, {(CB-1){1'b1}}};
    lo = {1'b1, {(CB-1){1'b0}}};

    // Directed cases at the reset threshold.
    add_pair('{0, 0, 0, 0, 0, 0, 0, 0}, 0);                         // both points
    add_pair('{0, 0, 4096, 0, 2048, -4096, 2048, 4096}, 0);         // crossing
    add_pair('{0, 0, 4096, 0, 0, 4096, 4096, 4096}, 0);             // parallel
    add_pair('{0, 0, 4096, 0, 8192, 0, 12288, 0}, 1);               // collinear apart
    add_pair('{0, 0, 8192, 0, 4096, 0, 12288, 0}, 0);               // collinear overlap
    add_pair('{0, 0, 4096, 0, 8192, 4096, 12288, 8192}, 0);         // s clamps past end
    add_pair('{0, 0, 4096, 0, -8192, 4096, -4096, 8192}, 0);        // s clamps below
    add_pair('{0, 0, 4096, 4096, 8192, 0, 16384, 1}, 2);            // t clamps
    add_pair('{0, 0, 0, 0, -4096, 4096, 4096, 4096}, 0);            // A is a point
    add_pair('{-4096, 4096, 4096, 4096, 0, 0, 0, 0}, 0);            // B is a point
    add_pair('{lo, lo, hi, hi, hi, lo, lo, hi}, 0);                 // full diagonals
    add_pair('{lo, lo, lo, hi, hi, lo, hi, hi}, 0);                 // far parallel
    add_pair('{hi, hi, hi, hi, lo, lo, lo, lo}, 3);                 // farthest points
    add_pair('{lo, hi, hi, lo, lo, hi, hi, lo}, 0);                 // identical segments
    add_pair('{0, 0, 3, 1, 1, 2, 2, -1}, 0);                        // tiny near-zero values
    add_pair('{-1, -1, 1, 1, 1, -1, -1, 1}, 0);
    add_pair('{0, 0, 4096, 0, 4096, 0, 8192, 4096}, 0);             // shared endpoint

    // The random part runs at several thresholds, the extremes among them.
    thr_plan = '{THR_RESET, 32'd0, 32'hFFFF_FFFF, 32'd1000, $urandom, 32'd1};
    for (int phase = 0; phase < 6; phase++) begin
      if (phase != 0) add_marker(REQ_CONFIG, thr_plan[phase]);
      add_random_phase(280);
      // Let everything drain once, near the end of phase 2.
      if (phase == 2) begin
        add_marker(REQ_DRAIN, '0);
        add_random_phase(20);
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() != 0 || expected_points.size() != 0 || start)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && expected_points.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// ===== segment_segment_distance.f =====
+incdir+hw/rtl
hw/rtl/ssd_pkg.sv
hw/rtl/ssd_wmul.sv
hw/rtl/segment_segment_distance.sv
tb/sv/segment_segment_distance_test.sv
